// ----- design/ccl_pkg.sv -----
// Shared types and constants of the connected-component labeler.
package ccl_pkg;

    localparam int NODES_DEF = 1024;
    localparam int ID_W      = 10;
    localparam int LBL_W     = 10;
    localparam int LINK_W    = 32;

    localparam logic [LBL_W-1:0]  LABEL_NONE      = 10'd0;
    localparam logic [LBL_W-1:0]  LABEL_MAX       = 10'd1023;
    localparam logic [LINK_W-1:0] MIN_SUPPORT_RST = 32'd15;

    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // What an add-edge request does to the label table.
    typedef enum logic [2:0] {
        OC_REJECT = 3'd0,
        OC_NEW    = 3'd1,
        OC_COPY_A = 3'd2,
        OC_COPY_B = 3'd3,
        OC_SAME   = 3'd4,
        OC_MERGE  = 3'd5
    } outcome_t;

    typedef struct packed {
        logic clear_step;
        logic take_req;
        logic rd_a;
        logic rd_b;
        logic cap_la;
        logic cap_read;
        logic decide;
        logic wr_b;
        logic walk_step;
        logic walk_flush;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     is_read;
        logic     walk_last;
        logic     slot_free;
    } dp_status_t;

endpackage

// ----- design/ccl_if.sv -----
// Request, result and configuration channels of the labeler.
interface ccl_req_if import ccl_pkg::*;;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [LINK_W-1:0] link_count;

    modport source (output valid, command, node_a, node_b, link_count, input ready);
    modport sink   (input valid, command, node_a, node_b, link_count, output ready);
endinterface

interface ccl_rsp_if import ccl_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LBL_W-1:0] label;
    logic             merged;
    logic [LBL_W-1:0] label_count;

    modport source (output valid, label, merged, label_count, input ready);
    modport sink   (input valid, label, merged, label_count, output ready);
endinterface

interface ccl_cfg_if import ccl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [LINK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/ccl_ctrl.sv -----
// Sequencer of the labeler: clearing pass, table lookups, updates and merge walk.
module ccl_ctrl import ccl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_RDA    = 10'b00_0000_0100,
        S_RDB    = 10'b00_0000_1000,
        S_RDRES  = 10'b00_0001_0000,
        S_DEC    = 10'b00_0010_0000,
        S_WRB    = 10'b00_0100_0000,
        S_WALK   = 10'b00_1000_0000,
        S_WEND   = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.take_req = req_valid;
                if (req_valid)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.rd_a   = 1'b1;
                state_next = status.is_read ? S_RDRES : S_RDB;
            end
            S_RDRES:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_DONE;
            end
            S_RDB:
            begin
                cmd.cap_la = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                case (status.outcome)
                    OC_NEW:   state_next = S_WRB;
                    OC_MERGE: state_next = S_WALK;
                    default:  state_next = S_DONE;
                endcase
            end
            S_WRB:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_WEND;
                end
            end
            S_WEND:
            begin
                cmd.walk_flush = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                cmd.load_out = status.slot_free;
                if (status.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/ccl_dp.sv -----
// Datapath of the labeler: label table, label counter, decision and result register.
module ccl_dp import ccl_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              command,
    input  logic [ID_W-1:0]   node_a,
    input  logic [ID_W-1:0]   node_b,
    input  logic [LINK_W-1:0] link_count,
    ccl_cfg_if.sink           cfg,
    ccl_rsp_if.source         rsp,
    input  dp_cmd_t           cmd,
    output dp_status_t        status
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODES - 1);

    logic [LBL_W-1:0]  mem [NODES];
    logic [LBL_W-1:0]  rd_data_reg;

    logic [LINK_W-1:0] min_support_reg;
    logic [LBL_W-1:0]  issued_reg;

    logic              item_cmd_reg;
    logic [ID_W-1:0]   item_a_reg;
    logic [ID_W-1:0]   item_b_reg;
    logic [LINK_W-1:0] item_links_reg;

    logic [LBL_W-1:0]  la_reg;
    logic [LBL_W-1:0]  keep_reg;
    logic [LBL_W-1:0]  drop_reg;
    logic [LBL_W-1:0]  res_label_reg;
    logic              res_merged_reg;

    logic [IDX_W-1:0]  walk_idx_reg;
    logic [IDX_W-1:0]  walk_prev_reg;
    logic              walk_pend_reg;

    logic              out_valid_reg;
    logic [LBL_W-1:0]  out_label_reg;
    logic              out_merged_reg;
    logic [LBL_W-1:0]  out_count_reg;

    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;
    logic              a_in_range;
    logic              b_in_range;
    logic              edge_ok;
    logic [LBL_W-1:0]  lb;
    logic [LBL_W-1:0]  new_label;
    outcome_t          outcome;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LBL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    assign a_idx      = IDX_W'(item_a_reg);
    assign b_idx      = IDX_W'(item_b_reg);
    assign a_in_range = 32'(item_a_reg) < 32'(NODES);
    assign b_in_range = 32'(item_b_reg) < 32'(NODES);
    assign edge_ok    = (item_cmd_reg == CMD_EDGE) && (item_links_reg >= min_support_reg) &&
                        (item_a_reg != item_b_reg) && a_in_range && b_in_range;
    assign lb         = rd_data_reg;
    assign new_label  = issued_reg + 1'b1;

    // Classify the edge once both labels are in hand.
    always_comb
    begin
        if (!edge_ok)
        begin
            outcome = OC_REJECT;
        end
        else if (la_reg == LABEL_NONE && lb == LABEL_NONE)
        begin
            outcome = (issued_reg < LABEL_MAX) ? OC_NEW : OC_REJECT;
        end
        else if (la_reg == LABEL_NONE)
        begin
            outcome = OC_COPY_A;
        end
        else if (lb == LABEL_NONE)
        begin
            outcome = OC_COPY_B;
        end
        else if (la_reg == lb)
        begin
            outcome = OC_SAME;
        end
        else
        begin
            outcome = OC_MERGE;
        end
    end

    assign status.outcome   = outcome;
    assign status.is_read   = (item_cmd_reg == CMD_READ);
    assign status.walk_last = (walk_idx_reg == IDX_LAST);
    assign status.slot_free = !out_valid_reg || rsp.ready;

    // Table port steering.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_idx_reg;
        mem_wdata = LABEL_NONE;
        mem_re    = 1'b0;
        mem_raddr = a_idx;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        if (cmd.decide)
        begin
            case (outcome)
                OC_NEW:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = a_idx;
                    mem_wdata = new_label;
                end
                OC_COPY_A:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = a_idx;
                    mem_wdata = lb;
                end
                OC_COPY_B:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = b_idx;
                    mem_wdata = la_reg;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        if (cmd.wr_b)
        begin
            mem_we    = 1'b1;
            mem_waddr = b_idx;
            mem_wdata = res_label_reg;
        end
        if ((cmd.walk_step || cmd.walk_flush) && walk_pend_reg && rd_data_reg == drop_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = walk_prev_reg;
            mem_wdata = keep_reg;
        end
        if (cmd.rd_a)
        begin
            mem_re    = 1'b1;
            mem_raddr = a_idx;
        end
        if (cmd.rd_b)
        begin
            mem_re    = 1'b1;
            mem_raddr = b_idx;
        end
        if (cmd.walk_step)
        begin
            mem_re    = 1'b1;
            mem_raddr = walk_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            item_cmd_reg   <= command;
            item_a_reg     <= node_a;
            item_b_reg     <= node_b;
            item_links_reg <= link_count;
        end
        if (cmd.cap_la)
        begin
            la_reg <= rd_data_reg;
        end
        if (cmd.cap_read)
        begin
            res_label_reg  <= a_in_range ? rd_data_reg : LABEL_NONE;
            res_merged_reg <= 1'b0;
        end
        if (cmd.decide)
        begin
            keep_reg       <= (la_reg < lb) ? la_reg : lb;
            drop_reg       <= (la_reg < lb) ? lb : la_reg;
            res_merged_reg <= (outcome == OC_MERGE);
            case (outcome)
                OC_NEW:    res_label_reg <= new_label;
                OC_COPY_A: res_label_reg <= lb;
                OC_COPY_B: res_label_reg <= la_reg;
                OC_SAME:   res_label_reg <= la_reg;
                OC_MERGE:  res_label_reg <= (la_reg < lb) ? la_reg : lb;
                default:   res_label_reg <= LABEL_NONE;
            endcase
        end
        if (cmd.walk_step)
        begin
            walk_prev_reg <= walk_idx_reg;
        end
        if (cmd.load_out)
        begin
            out_label_reg  <= res_label_reg;
            out_merged_reg <= res_merged_reg;
            out_count_reg  <= issued_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg <= MIN_SUPPORT_RST;
            issued_reg      <= LABEL_NONE;
            walk_idx_reg    <= '0;
            walk_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                min_support_reg <= cfg.data;
            end
            if (cmd.decide && outcome == OC_NEW)
            begin
                issued_reg <= new_label;
            end
            if (cmd.clear_step || cmd.walk_step)
            begin
                walk_idx_reg <= (walk_idx_reg == IDX_LAST) ? '0 : walk_idx_reg + 1'b1;
            end
            else if (cmd.decide)
            begin
                walk_idx_reg <= '0;
            end
            if (cmd.walk_step)
            begin
                walk_pend_reg <= 1'b1;
            end
            else if (cmd.decide || cmd.walk_flush)
            begin
                walk_pend_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.label       = out_label_reg;
    assign rsp.merged      = out_merged_reg;
    assign rsp.label_count = out_count_reg;

    a_walk_keeps_smaller: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step || cmd.walk_flush) && mem_we |-> mem_wdata == keep_reg && keep_reg < drop_reg)
        else $error("merge walk wrote a label other than the kept one");

    a_issued_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg != $past(issued_reg) |-> issued_reg == $past(issued_reg) + 1'b1)
        else $error("issued label count moved by other than one");

    a_merge_has_label: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && res_merged_reg |-> res_label_reg != LABEL_NONE)
        else $error("merge result without a label");

    a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !cmd.clear_step |-> mem_wdata != LABEL_NONE)
        else $error("table update outside clearing wrote label zero");

endmodule

// ----- design/connected_component_labeler.sv -----
// Top level of the connected-component labeler: sequencer plus datapath.
// A read looks up node_a and returns its label; an edge looks up node_a, then node_b,
// then decides, a fresh-label edge also writes node_b and a merging edge walks the table
// (one table entry a cycle). A new request is taken only once the last result is in the
// output register. Reset: rst_n clears control at once, then a clearing pass zeroes the
// table; requests wait for it, configuration writes are taken throughout.
module connected_component_labeler import ccl_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ccl_req_if.sink   req,
    ccl_rsp_if.source rsp,
    ccl_cfg_if.sink   cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_ready;

    // Hand requests to the sequencer; it takes one only when idle.
    assign req.ready = req_ready;

    ccl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the table, the label counter and the result register.
    ccl_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (req.command),
        .node_a     (req.node_a),
        .node_b     (req.node_b),
        .link_count (req.link_count),
        .cfg        (cfg),
        .rsp        (rsp),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
